/* rtl/bse_pkg.sv */
// shared constants, types and helpers for the bitmap set engine
`default_nettype none

package bse_pkg;

	localparam int SET_BITS  = 1024;
	localparam int WORD_W    = 32;
	localparam int OFS_W     = $clog2(WORD_W);
	localparam int SET_WORDS = (SET_BITS + WORD_W - 1) / WORD_W;
	localparam int WORD_AW   = $clog2(SET_WORDS);
	localparam int WCNT_W    = WORD_AW + 1;
	localparam int CAP_W     = $clog2(SET_BITS + 1);

	localparam int CMD_W  = 4;
	localparam int IDX_W  = 11;
	localparam int WIDX_W = 5;
	localparam int POS_W  = 10;
	localparam int CNT_W  = 11;

	typedef enum logic [CMD_W-1:0] {
		CMD_CLEAR  = 4'd0,
		CMD_WRITE  = 4'd1,
		CMD_TEST   = 4'd2,
		CMD_FIND   = 4'd3,
		CMD_COUNT  = 4'd4,
		CMD_INVERT = 4'd5,
		CMD_AND    = 4'd6,
		CMD_OR     = 4'd7,
		CMD_XOR    = 4'd8
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_RESP
	} state_t;

	typedef struct packed {
		logic [WORD_W-1:0] new_word;
		logic [OFS_W:0]    pop;
		logic              any;
		logic [OFS_W-1:0]  first;
	} alu_res_t;

	// bits of word w that lie inside the set capacity
	function automatic logic [WORD_W-1:0] word_mask(input logic [WORD_AW-1:0] w);
		int lo;
		lo = int'(w) * WORD_W;
		if (lo + WORD_W <= SET_BITS) begin
			return '1;
		end
		return (WORD_W'(1) << (SET_BITS - lo)) - WORD_W'(1);
	endfunction

endpackage

`default_nettype wire

/* rtl/bse_ram.sv */
// generic single write, single read ram with registered read data
`default_nettype none

module bse_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

/* rtl/bse_word_alu.sv */
// shared word unit: bit update, logic combine, population count, first set bit
`default_nettype none

module bse_word_alu (
	input  wire bse_pkg::cmd_t                 op,
	input  wire logic [bse_pkg::WORD_W-1:0]    word,
	input  wire logic [bse_pkg::WORD_W-1:0]    opnd,
	input  wire logic [bse_pkg::WORD_W-1:0]    wmask,
	input  wire logic                          bit_value,
	output      bse_pkg::alu_res_t             res
);
	import bse_pkg::*;

	localparam int NIBS = WORD_W / 4;

	logic [WORD_W-1:0] new_word;
	logic [WORD_W-1:0] sel;
	logic [WORD_W-1:0] low;
	logic [2:0]        nib_cnt [NIBS];
	logic [OFS_W:0]    pop;
	logic [OFS_W-1:0]  first;

	// new word contents
	always_comb begin
		case (op)
			CMD_WRITE:  new_word = bit_value ? (word | opnd) : (word & ~opnd);
			CMD_INVERT: new_word = word ^ opnd;
			CMD_AND:    new_word = (word & opnd) & wmask;
			CMD_OR:     new_word = (word | opnd) & wmask;
			CMD_XOR:    new_word = (word ^ opnd) & wmask;
			default:    new_word = word;
		endcase
	end

	// population count: nibbles, then a short sum
	always_comb begin
		for (int k = 0; k < NIBS; k++) begin
			nib_cnt[k] = 3'(word[4*k]) + 3'(word[4*k+1]) + 3'(word[4*k+2]) + 3'(word[4*k+3]);
		end
		pop = '0;
		for (int k = 0; k < NIBS; k++) begin
			pop = pop + (OFS_W+1)'(nib_cnt[k]);
		end
	end

	// lowest selected bit, isolated then encoded
	always_comb begin
		sel   = word & opnd;
		low   = sel & (~sel + WORD_W'(1));
		first = '0;
		for (int i = 0; i < WORD_W; i++) begin
			if (low[i]) begin
				first = first | OFS_W'(i);
			end
		end
	end

	// fields in struct order: new word, count, any, first
	assign res = {new_word, pop, |sel, first};

endmodule

`default_nettype wire

/* rtl/bitmap_set_engine.sv */
// bitmap set engine top level: command sequencer, word store and result register
// flow: clear, unused commands and most out-of-range commands go straight to the result;
//   single-word commands (write, test, and/or/xor) walk one word; find next, count and
//   invert walk up to 32 words, one ram read per cycle, also after clamping a bad operand
// throughput: one item at a time; the next item is taken the cycle after the result
//   enters the output register, so the single ram read port and the word walk set the rate
// reset: the set reads empty right after reset through per-word valid bits, no clearing pass
`default_nettype none

module bitmap_set_engine (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output      logic                         in_stall,
	input  wire logic [bse_pkg::CMD_W-1:0]    cmd,
	input  wire logic [bse_pkg::IDX_W-1:0]    bit_index,
	input  wire logic                         bit_value,
	input  wire logic [bse_pkg::CAP_W-1:0]    universe_size,
	input  wire logic [bse_pkg::WIDX_W-1:0]   word_index,
	input  wire logic [bse_pkg::WORD_W-1:0]   word_data,
	output      logic                         out_valid,
	input  wire logic                         out_stall,
	output      logic                         hit,
	output      logic [bse_pkg::POS_W-1:0]    position,
	output      logic [bse_pkg::CNT_W-1:0]    member_count,
	output      logic                         range_error
);
	import bse_pkg::*;

	// sequencer state and per-item registers
	state_t              state_q, state_d;
	cmd_t                cmd_q;
	logic [CAP_W-1:0]    bound_q;      // bit index, find start or invert size
	logic                bit_value_q;
	logic [WORD_W-1:0]   data_q;
	logic [WCNT_W-1:0]   rd_addr_q;    // next word to read
	logic [WCNT_W-1:0]   end_q;        // one past the last word of the walk
	logic                hit_q, found_q, err_q;
	logic [POS_W-1:0]    pos_q;
	logic [CNT_W-1:0]    cnt_q;

	// read stage: word data comes back from the ram in the cycle after the read
	logic                v_s1;
	logic [WORD_AW-1:0]  addr_s1;

	// one valid bit per word; an invalid word reads as zero
	logic [SET_WORDS-1:0] vld_q;

	// result register
	logic                out_valid_q, out_hit_q, out_err_q;
	logic [POS_W-1:0]    out_pos_q;
	logic [CNT_W-1:0]    out_cnt_q;

	// accept-time decode
	cmd_t                cmd_in;
	logic signed [31:0]  idx_s;
	logic                idx_neg, idx_over;
	logic                acc_walk, acc_err;
	logic [CAP_W-1:0]    acc_bound, us_m1;
	logic [WCNT_W-1:0]   acc_start, acc_end;

	logic                in_fire, issue, load_out, wr_en;
	logic [WORD_W-1:0]   ram_rdata, cur_word, opnd, wmask;
	alu_res_t            alu_res;
	logic [CNT_W:0]      cnt_sum;

	assign in_fire  = in_valid && !in_stall;
	assign cmd_in   = cmd_t'(cmd);
	assign idx_s    = 32'(signed'(bit_index));
	assign idx_neg  = bit_index[IDX_W-1];
	assign idx_over = idx_s >= SET_BITS;

	// work out the word range to walk and any range error up front
	always_comb begin
		acc_walk  = 1'b0;
		acc_err   = 1'b0;
		acc_bound = '0;
		acc_start = '0;
		acc_end   = '0;
		us_m1     = '0;
		case (cmd_in)
			CMD_WRITE, CMD_TEST: begin
				if (idx_over || (idx_neg && cmd_in == CMD_WRITE)) begin
					acc_err = 1'b1;
				end else if (!idx_neg) begin
					acc_walk  = 1'b1;
					acc_bound = bit_index;
					acc_start = acc_bound[CAP_W-1:OFS_W];
					acc_end   = acc_start + WCNT_W'(1);
				end
			end
			CMD_FIND: begin
				// below minus one clamps to a search from member 0
				if (idx_s < -1) begin
					acc_err   = 1'b1;
					acc_bound = '0;
				end else if (idx_over) begin
					acc_err   = 1'b1;
				end else begin
					acc_bound = CAP_W'(idx_s + 1);
				end
				if (!idx_over && acc_bound != CAP_W'(SET_BITS)) begin
					acc_walk  = 1'b1;
					acc_start = acc_bound[CAP_W-1:OFS_W];
					acc_end   = WCNT_W'(SET_WORDS);
				end
			end
			CMD_COUNT: begin
				acc_walk = 1'b1;
				acc_end  = WCNT_W'(SET_WORDS);
			end
			CMD_INVERT: begin
				// size saturates at capacity
				if (universe_size > CAP_W'(SET_BITS)) begin
					acc_err   = 1'b1;
					acc_bound = CAP_W'(SET_BITS);
				end else begin
					acc_bound = universe_size;
				end
				us_m1 = acc_bound - CAP_W'(1);
				if (acc_bound != '0) begin
					acc_walk = 1'b1;
					acc_end  = us_m1[CAP_W-1:OFS_W] + WCNT_W'(1);
				end
			end
			CMD_AND, CMD_OR, CMD_XOR: begin
				if (WCNT_W'(word_index) >= WCNT_W'(SET_WORDS)) begin
					acc_err = 1'b1;
				end else begin
					acc_walk  = 1'b1;
					acc_start = WCNT_W'(word_index);
					acc_end   = acc_start + WCNT_W'(1);
				end
			end
			default: begin
			end
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					state_d = acc_walk ? ST_WALK : ST_RESP;
				end
			end
			ST_WALK: begin
				// done once no read is left to issue and none is in flight
				if (!issue && !v_s1) begin
					state_d = ST_RESP;
				end
			end
			ST_RESP: begin
				if (load_out) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_stall = 1'b1;
		issue    = 1'b0;
		load_out = 1'b0;
		case (state_q)
			ST_IDLE: in_stall = 1'b0;
			ST_WALK: issue    = (rd_addr_q != end_q) && !found_q;
			ST_RESP: load_out = !out_valid_q || !out_stall;
			default: begin
			end
		endcase
	end

	// word store
	bse_ram #(
		.WIDTH (WORD_W),
		.DEPTH (SET_WORDS)
	) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (addr_s1),
		.wdata (alu_res.new_word),
		.re    (issue),
		.raddr (rd_addr_q[WORD_AW-1:0]),
		.rdata (ram_rdata)
	);

	assign cur_word = vld_q[addr_s1] ? ram_rdata : '0;
	assign wmask    = word_mask(addr_s1);

	// the walk never revisits a word, so write-back goes to the word just read
	always_comb begin
		case (cmd_q)
			CMD_WRITE, CMD_INVERT, CMD_AND, CMD_OR, CMD_XOR: wr_en = v_s1;
			default:                                         wr_en = 1'b0;
		endcase
	end

	// operand for the shared word unit
	always_comb begin
		case (cmd_q)
			CMD_WRITE, CMD_TEST: opnd = WORD_W'(1) << bound_q[OFS_W-1:0];
			CMD_FIND: begin
				// first word of the search drops the bits below the start
				if (WCNT_W'(addr_s1) == bound_q[CAP_W-1:OFS_W]) begin
					opnd = {WORD_W{1'b1}} << bound_q[OFS_W-1:0];
				end else begin
					opnd = {WORD_W{1'b1}};
				end
			end
			CMD_INVERT: begin
				// whole words below the size, then a partial last word
				if (WCNT_W'(addr_s1) < bound_q[CAP_W-1:OFS_W]) begin
					opnd = {WORD_W{1'b1}};
				end else begin
					opnd = (WORD_W'(1) << bound_q[OFS_W-1:0]) - WORD_W'(1);
				end
			end
			CMD_AND, CMD_OR, CMD_XOR: opnd = data_q;
			default:                  opnd = '0;
		endcase
	end

	bse_word_alu u_alu (
		.op        (cmd_q),
		.word      (cur_word),
		.opnd      (opnd),
		.wmask     (wmask),
		.bit_value (bit_value_q),
		.res       (alu_res)
	);

	assign cnt_sum = {1'b0, cnt_q} + (CNT_W+1)'(alu_res.pop);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cmd_q       <= CMD_CLEAR;
			v_s1        <= 1'b0;
			vld_q       <= '0;
			rd_addr_q   <= '0;
			end_q       <= '0;
			hit_q       <= 1'b0;
			found_q     <= 1'b0;
			err_q       <= 1'b0;
			pos_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			v_s1    <= issue;

			if (in_fire) begin
				cmd_q     <= cmd_in;
				err_q     <= acc_err;
				hit_q     <= 1'b0;
				found_q   <= 1'b0;
				pos_q     <= '0;
				cnt_q     <= '0;
				rd_addr_q <= acc_start;
				end_q     <= acc_end;
				if (cmd_in == CMD_CLEAR) begin
					vld_q <= '0;
				end
			end else if (issue) begin
				rd_addr_q <= rd_addr_q + WCNT_W'(1);
			end

			if (v_s1) begin
				if (wr_en) begin
					vld_q[addr_s1] <= 1'b1;
				end
				case (cmd_q)
					CMD_TEST: hit_q <= alu_res.any;
					CMD_FIND: begin
						// a word read after the hit is ignored
						if (!found_q && alu_res.any) begin
							found_q <= 1'b1;
							hit_q   <= 1'b1;
							pos_q   <= POS_W'({addr_s1, alu_res.first});
						end
					end
					CMD_COUNT: cnt_q <= cnt_sum[CNT_W] ? '1 : cnt_sum[CNT_W-1:0];
					default: begin
					end
				endcase
			end

			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			bound_q     <= acc_bound;
			bit_value_q <= bit_value;
			data_q      <= word_data;
		end
		if (issue) begin
			addr_s1 <= rd_addr_q[WORD_AW-1:0];
		end
		if (load_out) begin
			out_hit_q <= hit_q;
			out_pos_q <= pos_q;
			out_cnt_q <= cnt_q;
			out_err_q <= err_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign hit          = out_hit_q;
	assign position     = out_pos_q;
	assign member_count = out_cnt_q;
	assign range_error  = out_err_q;

	// read data only comes back during a walk
	a_rd_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> state_q == ST_WALK)
		else $error("word data in flight outside a walk");

	// an accepted item always leaves idle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> state_q != ST_IDLE)
		else $error("sequencer stayed idle after accepting an item");

	// the walk pointer never runs past its end
	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WALK |-> rd_addr_q <= end_q)
		else $error("walk pointer past end of range");

	// a found flag only belongs to a find
	a_found_find: assert property (@(posedge clk) disable iff (!arst_n)
		found_q |-> cmd_q == CMD_FIND)
		else $error("found flag set outside find next");

	// member count never exceeds capacity
	a_cnt_cap: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> cnt_q <= CNT_W'(SET_BITS))
		else $error("member count above capacity");

endmodule

`default_nettype wire
